### design/route_best_path_select_defines.svh
// assertion macros for the best path select block
// used by the top level only; expects clk and rst in scope
`ifndef ROUTE_BEST_PATH_SELECT_DEFINES_SVH
`define ROUTE_BEST_PATH_SELECT_DEFINES_SVH

// same-cycle implication, off during reset
`define RBPS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RBPS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### design/rbps_pkg.sv
// shared types and constants for the best path select block
// no dependencies
package rbps_pkg;

  localparam int PREFIX_BLOCKS = 1024;
  localparam int MAX_PATH      = 64;

  localparam int PREFIX_W = 10;
  localparam int ASN_W    = 32;
  localparam int REL_W    = 2;
  localparam int LEN_W    = 7;
  localparam int CFG_W    = 32;
  localparam int ADDR_W   = (PREFIX_BLOCKS > 1) ? $clog2(PREFIX_BLOCKS) : 1;
  localparam int RUN_W    = $clog2(MAX_PATH + 1);
  localparam int NLEN_W   = RUN_W + 1;

  localparam logic [1:0] VERDICT_KEPT = 2'd0;
  localparam logic [1:0] VERDICT_NEW  = 2'd1;
  localparam logic [1:0] VERDICT_LOOP = 2'd2;

  localparam logic REG_OWN_ASN    = 1'b0;
  localparam logic REG_SENDER_REL = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [REL_W-1:0]  rel;
    logic [LEN_W-1:0]  len;
    logic [ASN_W-1:0]  nb;
  } entry_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last_hit;
    logic out_free;
  } ctrl_status_t;

endpackage

### design/route_best_path_select.sv
// top level of the per-prefix best route table
// depends on rbps_pkg, rbps_ctrl, rbps_datapath and the assertion macro header
//
// channel   handshake              payload
// in        in_valid / in_ready    prefix_id, path_asn, first_elem, last_elem
// out       out_valid / out_ready  out_prefix, verdict, best_length,
//                                  best_neighbor, best_relationship
// cfg       cfg_we                 cfg_index, cfg_data
//
// path elements are taken one per cycle while in_ready is high; a last mark starts
// a table read-modify-write with in_ready low (single-port write, registered read)
// after reset all 1024 table entries are cleared, one a cycle, with in_ready low
// a held result does not block streaming; a decision waits only until it is taken
// config writes are taken at any time, reset included only as clearing
`include "route_best_path_select_defines.svh"

module route_best_path_select (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rbps_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rbps_pkg::PREFIX_W-1:0]   prefix_id,
  input  logic [rbps_pkg::ASN_W-1:0]      path_asn,
  input  logic                            first_elem,
  input  logic                            last_elem,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rbps_pkg::PREFIX_W-1:0]   out_prefix,
  output logic [1:0]                      verdict,
  output logic [rbps_pkg::LEN_W-1:0]      best_length,
  output logic [rbps_pkg::ASN_W-1:0]      best_neighbor,
  output logic [rbps_pkg::REL_W-1:0]      best_relationship
);

  rbps_pkg::ctrl_cmd_t    cmd;
  rbps_pkg::ctrl_status_t status;

  rbps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rbps_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .prefix_id         (prefix_id),
    .path_asn          (path_asn),
    .first_elem        (first_elem),
    .last_elem         (last_elem),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_prefix        (out_prefix),
    .verdict           (verdict),
    .best_length       (best_length),
    .best_neighbor     (best_neighbor),
    .best_relationship (best_relationship),
    .cmd               (cmd),
    .status            (status)
  );

  `RBPS_ASSERT_NOW(a_no_ready_in_clear, cmd.clear_wr, !in_ready, "item taken during table clear")
  `RBPS_ASSERT_NEXT(a_decide_blocks_input, cmd.accept && status.last_hit, !in_ready, "input open during decision")
  `RBPS_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid, "decision without result")
  `RBPS_ASSERT_NOW(a_commit_has_room, cmd.commit, status.out_free, "result overwritten")

endmodule

### design/rbps_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/rbps_ctrl.sv
// controller: table clear, path streaming and per-announcement decision
// depends on rbps_pkg
module rbps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rbps_pkg::ctrl_status_t status,
  output rbps_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.clear_wr = 1'b0;
    cmd.accept   = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_done) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.last_hit) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // wait here while the previous result is still held
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/rbps_datapath.sv
// datapath: config registers, run tracking, route table and result register
// depends on rbps_pkg and rbps_ram
module rbps_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rbps_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rbps_pkg::PREFIX_W-1:0]   prefix_id,
  input  logic [rbps_pkg::ASN_W-1:0]      path_asn,
  input  logic                            first_elem,
  input  logic                            last_elem,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rbps_pkg::PREFIX_W-1:0]   out_prefix,
  output logic [1:0]                      verdict,
  output logic [rbps_pkg::LEN_W-1:0]      best_length,
  output logic [rbps_pkg::ASN_W-1:0]      best_neighbor,
  output logic [rbps_pkg::REL_W-1:0]      best_relationship,
  input  rbps_pkg::ctrl_cmd_t             cmd,
  output rbps_pkg::ctrl_status_t          status
);

  logic [rbps_pkg::ASN_W-1:0]    own_asn;
  logic [rbps_pkg::REL_W-1:0]    sender_rel;

  logic [rbps_pkg::RUN_W-1:0]    run_length;
  logic [rbps_pkg::ASN_W-1:0]    run_first_asn;
  logic                          run_loop_seen;

  logic [rbps_pkg::RUN_W-1:0]    hold_n;
  logic                          hold_loop;
  logic [rbps_pkg::ASN_W-1:0]    hold_nb;
  logic [rbps_pkg::PREFIX_W-1:0] hold_prefix;

  logic [rbps_pkg::ADDR_W-1:0]   clr_addr;

  logic [rbps_pkg::RUN_W-1:0]    base_len;
  logic [rbps_pkg::RUN_W-1:0]    len_upd;
  logic                          loop_upd;
  logic [rbps_pkg::ASN_W-1:0]    first_cur;

  logic [rbps_pkg::NLEN_W-1:0]   len_plus;
  logic [rbps_pkg::LEN_W-1:0]    new_len;
  rbps_pkg::entry_t              old_entry;
  rbps_pkg::entry_t              new_entry;
  rbps_pkg::entry_t              wr_entry;
  logic                          new_wins;
  logic                          store_new;
  logic                          ram_we;
  logic [rbps_pkg::ADDR_W-1:0]   ram_waddr;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_asn    <= '0;
      sender_rel <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbps_pkg::REG_OWN_ASN:    own_asn    <= cfg_data[rbps_pkg::ASN_W-1:0];
        rbps_pkg::REG_SENDER_REL: sender_rel <= cfg_data[rbps_pkg::REL_W-1:0];
        default: ;
      endcase
    end
  end

  // run tracking for the item being accepted
  always_comb begin
    base_len  = first_elem ? '0 : run_length;
    len_upd   = (base_len < rbps_pkg::RUN_W'(rbps_pkg::MAX_PATH))
                ? base_len + rbps_pkg::RUN_W'(1) : base_len;
    loop_upd  = (first_elem ? 1'b0 : run_loop_seen) | (path_asn == own_asn);
    first_cur = first_elem ? path_asn : run_first_asn;
  end

  assign status.last_hit =
    last_elem && (32'(prefix_id) < 32'(rbps_pkg::PREFIX_BLOCKS));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length    <= '0;
      run_first_asn <= '0;
      run_loop_seen <= 1'b0;
    end else if (cmd.accept) begin
      run_first_asn <= first_cur;
      if (last_elem) begin
        run_length    <= '0;
        run_loop_seen <= 1'b0;
      end else begin
        run_length    <= len_upd;
        run_loop_seen <= loop_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last_elem) begin
      hold_n      <= len_upd;
      hold_loop   <= loop_upd;
      hold_nb     <= first_cur;
      hold_prefix <= prefix_id;
    end
  end

  // table clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + rbps_pkg::ADDR_W'(1);
    end
  end

  assign status.clear_done = (clr_addr == rbps_pkg::ADDR_W'(rbps_pkg::PREFIX_BLOCKS - 1));

  // decision against the stored entry
  always_comb begin
    len_plus = rbps_pkg::NLEN_W'(hold_n) + rbps_pkg::NLEN_W'(1);
    if (len_plus > rbps_pkg::NLEN_W'(rbps_pkg::MAX_PATH)) begin
      new_len = rbps_pkg::LEN_W'(rbps_pkg::MAX_PATH);
    end else begin
      new_len = rbps_pkg::LEN_W'(len_plus);
    end

    new_entry.valid = 1'b1;
    new_entry.rel   = sender_rel;
    new_entry.len   = new_len;
    new_entry.nb    = hold_nb;

    if (!old_entry.valid) begin
      new_wins = 1'b1;
    end else if (sender_rel != old_entry.rel) begin
      new_wins = sender_rel > old_entry.rel;
    end else if (old_entry.len != new_len) begin
      new_wins = old_entry.len > new_len;
    end else begin
      new_wins = hold_nb < old_entry.nb;
    end

    store_new = !hold_loop && new_wins;
    ram_we    = cmd.clear_wr || (cmd.commit && store_new);
    ram_waddr = cmd.clear_wr ? clr_addr : rbps_pkg::ADDR_W'(hold_prefix);
    wr_entry  = cmd.clear_wr ? '0 : new_entry;
  end

  rbps_ram #(
    .WIDTH ($bits(rbps_pkg::entry_t)),
    .DEPTH (rbps_pkg::PREFIX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (cmd.accept && last_elem),
    .raddr (rbps_pkg::ADDR_W'(prefix_id)),
    .rdata (old_entry)
  );

  // result register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_prefix <= hold_prefix;
      if (hold_loop) begin
        verdict <= rbps_pkg::VERDICT_LOOP;
      end else if (new_wins) begin
        verdict <= rbps_pkg::VERDICT_NEW;
      end else begin
        verdict <= rbps_pkg::VERDICT_KEPT;
      end
      if (store_new) begin
        best_length       <= new_len;
        best_neighbor     <= hold_nb;
        best_relationship <= sender_rel;
      end else if (old_entry.valid) begin
        best_length       <= old_entry.len;
        best_neighbor     <= old_entry.nb;
        best_relationship <= old_entry.rel;
      end else begin
        best_length       <= '0;
        best_neighbor     <= '0;
        best_relationship <= '0;
      end
    end
  end

endmodule
